@@ sv/lzd_pkg.sv @@
// Shared types and constants for the LZSS decompressor.
// Used by lzd_ctrl, lzd_datapath and lzss_decompressor_core; no dependencies.
package lzd_pkg;

  // Default history window depth in bytes
  localparam int HISTORY_DEPTH_DEF = 4096;

  // Reference field widths
  localparam int DIST_W = 12;
  localparam int LEN_W  = 4;

  // Width for window address arithmetic (distance plus depth)
  localparam int SUM_W = DIST_W + 1;

  // Items per flag byte
  localparam logic [3:0] GROUP_SIZE = 4'd8;

  // Controller states
  typedef enum logic {
    ST_IDLE,
    ST_COPY
  } state_t;

  // Role of an incoming compressed byte
  typedef enum logic [1:0] {
    KIND_FLAG,
    KIND_FIRST,
    KIND_SECOND,
    KIND_LITERAL
  } kind_t;

  // Controller to datapath
  typedef struct packed {
    logic take_in;
    logic copy_step;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic copy_go;
    logic copy_final;
    logic out_free;
  } dp_status_t;

endpackage

@@ sv/lzd_ctrl.sv @@
// Controller state machine of the LZSS decompressor.
// Depends on lzd_pkg; drives commands into lzd_datapath.
module lzd_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  lzd_pkg::dp_status_t sts,
  output lzd_pkg::ctrl_cmd_t  cmd
);

  lzd_pkg::state_t state_r, state_nxt;

  // Hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lzd_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state: enter copy on a good reference, leave after its last byte
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lzd_pkg::ST_IDLE: begin
        if (sts.copy_go) begin
          state_nxt = lzd_pkg::ST_COPY;
        end
      end
      lzd_pkg::ST_COPY: begin
        if (sts.out_free && sts.copy_final) begin
          state_nxt = lzd_pkg::ST_IDLE;
        end
      end
      default: state_nxt = lzd_pkg::ST_IDLE;
    endcase
  end

  // Commands: take input when idle, step the copy when copying; each only while the output slot is free
  always_comb begin
    cmd = '0;
    unique case (state_r)
      lzd_pkg::ST_IDLE: cmd.take_in   = sts.out_free;
      lzd_pkg::ST_COPY: cmd.copy_step = sts.out_free;
      default:          cmd = '0;
    endcase
  end

endmodule

@@ sv/lzd_datapath.sv @@
// Datapath of the LZSS decompressor: parse registers, history memory,
// copy pointer and output register. Depends on lzd_pkg; commanded by lzd_ctrl.
module lzd_datapath #(
  parameter int HISTORY_DEPTH = lzd_pkg::HISTORY_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic [7:0]          in_byte,
  input  logic                in_last,
  input  logic                out_stall,
  output logic                out_valid,
  output logic [7:0]          out_byte,
  output logic                out_last_of_run,
  output logic                out_bad_reference,
  input  lzd_pkg::ctrl_cmd_t  cmd,
  output lzd_pkg::dp_status_t sts
);

  localparam int AW = $clog2(HISTORY_DEPTH);
  localparam int CW = AW + 1;
  localparam int SW = lzd_pkg::SUM_W;

  // History window
  logic [7:0] mem [HISTORY_DEPTH];
  logic [7:0] rd_q;

  // Parse and window state
  logic [AW-1:0]             wp_r, wp_nxt;
  logic [CW-1:0]             cnt_r, cnt_nxt;
  logic [7:0]                flag_r, flag_nxt;
  logic [3:0]                pos_r, pos_nxt;
  logic                      await_r, await_nxt;
  logic [7:0]                first_r, first_nxt;
  logic                      clr_pend_r, clr_pend_nxt;
  logic [AW-1:0]             ptr_r, ptr_nxt;
  logic [lzd_pkg::LEN_W-1:0] left_r, left_nxt;

  // Output register
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_byte_r, out_byte_nxt;
  logic       out_last_r, out_last_nxt;
  logic       out_bad_r, out_bad_nxt;

  // Decode
  lzd_pkg::kind_t            kind;
  logic                      accept;
  logic [lzd_pkg::DIST_W-1:0] ref_dist;
  logic [lzd_pkg::LEN_W-1:0] len;
  logic [SW-1:0]             dist_w, wp_w, start_w;
  logic                      bad;
  logic                      lit_go, sec_go, err_go, copy_go;
  logic                      store_en;
  logic [7:0]                store_data;
  logic [AW-1:0]             wp_inc, ptr_inc;
  logic [3:0]                pos_inc;
  logic                      out_free;
  logic                      clear_now;

  // Classify the incoming byte and check the reference
  always_comb begin
    priority if (pos_r == 4'd0) begin
      kind = lzd_pkg::KIND_FLAG;
    end else if (await_r) begin
      kind = lzd_pkg::KIND_SECOND;
    end else if (flag_r[3'(lzd_pkg::GROUP_SIZE - pos_r)]) begin
      kind = lzd_pkg::KIND_FIRST;
    end else begin
      kind = lzd_pkg::KIND_LITERAL;
    end
  end

  assign accept   = in_valid && cmd.take_in;
  assign ref_dist = {first_r, in_byte[7:4]};
  assign len      = in_byte[3:0];
  assign dist_w   = SW'(ref_dist);
  assign wp_w     = SW'(wp_r);
  assign bad      = (dist_w < SW'(len)) || (dist_w > SW'(cnt_r));
  assign start_w  = (wp_w >= dist_w) ? (wp_w - dist_w)
                                     : (wp_w + SW'(HISTORY_DEPTH) - dist_w);

  assign lit_go  = accept && (kind == lzd_pkg::KIND_LITERAL);
  assign sec_go  = accept && (kind == lzd_pkg::KIND_SECOND);
  assign err_go  = sec_go && (len != '0) && bad;
  assign copy_go = sec_go && (len != '0) && !bad;

  assign out_free = !out_valid_r || !out_stall;

  assign sts.copy_go    = copy_go;
  assign sts.copy_final = (left_r == lzd_pkg::LEN_W'(1));
  assign sts.out_free   = out_free;

  // Wrapping increments
  assign wp_inc  = (wp_r == AW'(HISTORY_DEPTH - 1)) ? '0 : wp_r + AW'(1);
  assign ptr_inc = (ptr_r == AW'(HISTORY_DEPTH - 1)) ? '0 : ptr_r + AW'(1);
  assign pos_inc = (pos_r == lzd_pkg::GROUP_SIZE) ? 4'd0 : pos_r + 4'd1;

  // Store literals and copied bytes
  assign store_en   = lit_go || cmd.copy_step;
  assign store_data = lit_go ? in_byte : rd_q;

  // Read pointer runs one ahead so read data lines up with the copy step
  always_comb begin
    priority if (copy_go) begin
      ptr_nxt = start_w[AW-1:0];
    end else if (cmd.copy_step) begin
      ptr_nxt = ptr_inc;
    end else begin
      ptr_nxt = ptr_r;
    end
  end

  // Copy length counter and deferred end-of-stream clear
  always_comb begin
    left_nxt     = left_r;
    clr_pend_nxt = clr_pend_r;
    if (copy_go) begin
      left_nxt     = len;
      clr_pend_nxt = in_last;
    end else if (cmd.copy_step) begin
      left_nxt = left_r - lzd_pkg::LEN_W'(1);
    end
  end

  // Parse state update
  always_comb begin
    flag_nxt  = flag_r;
    pos_nxt   = pos_r;
    await_nxt = await_r;
    first_nxt = first_r;
    if (accept) begin
      unique case (kind)
        lzd_pkg::KIND_FLAG: begin
          flag_nxt = in_byte;
          pos_nxt  = 4'd1;
        end
        lzd_pkg::KIND_FIRST: begin
          first_nxt = in_byte;
          await_nxt = 1'b1;
        end
        lzd_pkg::KIND_SECOND: begin
          await_nxt = 1'b0;
          pos_nxt   = pos_inc;
        end
        lzd_pkg::KIND_LITERAL: begin
          pos_nxt = pos_inc;
        end
        default: pos_nxt = pos_r;
      endcase
      if (in_last) begin
        flag_nxt  = '0;
        pos_nxt   = '0;
        await_nxt = 1'b0;
        first_nxt = '0;
      end
    end
  end

  // Window pointer and count; a stream end waits for its copy to finish
  assign clear_now = (accept && in_last && !copy_go) ||
                     (cmd.copy_step && sts.copy_final && clr_pend_r);

  always_comb begin
    wp_nxt  = wp_r;
    cnt_nxt = cnt_r;
    if (clear_now) begin
      wp_nxt  = '0;
      cnt_nxt = '0;
    end else if (store_en) begin
      wp_nxt = wp_inc;
      if (cnt_r < CW'(HISTORY_DEPTH)) begin
        cnt_nxt = cnt_r + CW'(1);
      end
    end
  end

  // Output register: load a literal, an error or a copied byte
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    out_bad_nxt   = out_bad_r;
    priority if (lit_go) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = in_byte;
      out_last_nxt  = 1'b1;
      out_bad_nxt   = 1'b0;
    end else if (err_go) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = '0;
      out_last_nxt  = 1'b1;
      out_bad_nxt   = 1'b1;
    end else if (cmd.copy_step) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = rd_q;
      out_last_nxt  = sts.copy_final;
      out_bad_nxt   = 1'b0;
    end else begin
      out_bad_nxt = out_bad_r;
    end
  end

  // History memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (store_en) begin
      mem[wp_r] <= store_data;
    end
    rd_q <= mem[ptr_nxt];
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r        <= '0;
      cnt_r       <= '0;
      flag_r      <= '0;
      pos_r       <= '0;
      await_r     <= 1'b0;
      first_r     <= '0;
      clr_pend_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      wp_r        <= wp_nxt;
      cnt_r       <= cnt_nxt;
      flag_r      <= flag_nxt;
      pos_r       <= pos_nxt;
      await_r     <= await_nxt;
      first_r     <= first_nxt;
      clr_pend_r  <= clr_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    ptr_r      <= ptr_nxt;
    left_r     <= left_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
    out_bad_r  <= out_bad_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_byte          = out_byte_r;
  assign out_last_of_run   = out_last_r;
  assign out_bad_reference = out_bad_r;

endmodule

@@ sv/lzss_decompressor_core.sv @@
// LZSS decompressor: takes one compressed byte per item and delivers decoded
// bytes from a history window of HISTORY_DEPTH bytes held in a single-port-write,
// registered-read memory. Flag bytes, first reference bytes and literals are each
// taken as one item; a reference of length L is accepted and then gives L output
// bytes, one output byte per cycle while the output is not stalled, during which
// no new item is accepted. A bad reference gives one error item. While the output
// register is full and stalled, no input is taken and the copy does not step.
// Depends on lzd_pkg, lzd_ctrl and lzd_datapath.
module lzss_decompressor_core #(
  parameter int HISTORY_DEPTH = lzd_pkg::HISTORY_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_last_of_run,
  output logic       out_bad_reference
);

  lzd_pkg::ctrl_cmd_t  cmd;
  lzd_pkg::dp_status_t sts;

  // Sequence input acceptance and copy steps
  lzd_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .cmd   (cmd)
  );

  // Parse, store and emit
  lzd_datapath #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_byte           (in_byte),
    .in_last           (in_last),
    .out_stall         (out_stall),
    .out_valid         (out_valid),
    .out_byte          (out_byte),
    .out_last_of_run   (out_last_of_run),
    .out_bad_reference (out_bad_reference),
    .cmd               (cmd),
    .sts               (sts)
  );

  // Stall input unless the controller can take an item
  assign in_stall = !cmd.take_in;

endmodule

@@ sv/lzd_checker.sv @@
// Port-level checks for lzss_decompressor_core, bound to the top level.
// Depends only on the top level's ports.
module lzd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte,
  input logic       out_last_of_run,
  input logic       out_bad_reference
);

  // Output is empty right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // A stalled item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_byte) &&
      $stable(out_last_of_run) && $stable(out_bad_reference))
    else $error("stalled output item changed");

  // An error item is a zero byte that ends its run
  a_bad_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bad_reference |-> out_byte == 8'd0 && out_last_of_run)
    else $error("malformed error item");

  // No input is taken while a finished item is held back
  a_in_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> in_stall)
    else $error("input accepted while output blocked");

  // An error result never appears without an input the cycle before
  a_no_idle_err: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) && out_bad_reference |-> $past(in_valid && !in_stall))
    else $error("error item without input");

endmodule

bind lzss_decompressor_core lzd_checker u_lzd_checker (.*);
